// File: src/cone_ray_direction_sampler_core_assert.svh
// assertion macros shared by the cone sampler modules
// needs clk and arst_n in the scope of each use
`ifndef CONE_RAY_DIRECTION_SAMPLER_CORE_ASSERT_SVH
`define CONE_RAY_DIRECTION_SAMPLER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define CRDS_ASSERT_CLK(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
`define CRDS_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);
`else
`define CRDS_ASSERT_CLK(lbl, cond, msg)
`define CRDS_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

// File: src/crds_pkg.sv
// shared types and fixed-point constants for the cone ray direction sampler
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package crds_pkg;
	localparam int ANGLE_W   = 32;
	localparam int DIR_W     = 32;
	localparam int PICK_W    = 6;
	localparam int NCFG_W    = 7;
	localparam int CFG_IDX_W = 3;
	localparam int PHASE_W   = 32;
	localparam int Q30_W     = 31;
	localparam int SC_W      = 32;
	localparam int SPAN_W    = 33;
	localparam int OFF_W     = 34;
	localparam int THETA_W   = 36;
	localparam int ACC_W     = 34;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_NUM_CIRCLES    = 3'd0,
		CFG_MIN_OPENING    = 3'd1,
		CFG_MAX_OPENING    = 3'd2,
		CFG_OPENING_SPREAD = 3'd3,
		CFG_TILT_ABOUT_X   = 3'd4,
		CFG_TILT_ABOUT_Y   = 3'd5
	} cfg_idx_t;

	localparam logic [Q30_W-1:0] Q30_ONE    = 31'd1073741824;
	localparam logic [Q30_W-1:0] Q30_HALF   = 31'd536870912;
	localparam logic [Q30_W-1:0] C_INV6     = 31'd178956971;
	localparam logic [Q30_W-1:0] C_INV24    = 31'd44739243;
	localparam logic [Q30_W-1:0] C_INV120   = 31'd8947849;
	localparam logic [Q30_W-1:0] C_INV720   = 31'd1491308;
	localparam logic [Q30_W-1:0] C_INV5040  = 31'd213044;
	localparam logic [Q30_W-1:0] C_INV40320 = 31'd26630;
	localparam logic [31:0]      PI_Q30     = 32'd3373259426;
	localparam logic [29:0]      TURNS_PER_RAD = 30'd683565276;

	typedef logic signed [ACC_W-1:0] acc_t;

	typedef struct packed {
		logic signed [SC_W-1:0] s;
		logic signed [SC_W-1:0] c;
	} sc_t;
endpackage
`default_nettype wire

// File: src/crds_offset_table.sv
// per-cone opening offset table, rebuilt after reset and after each register write
// serial divider plus fill sweep; uses crds_pkg
`timescale 1ns / 1ps
`default_nettype none
`include "cone_ray_direction_sampler_core_assert.svh"
module crds_offset_table #(
	parameter int MAX_CIRCLES = 64
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  restart,
	input  wire [$clog2(MAX_CIRCLES)-1:0]        divisor,
	input  wire signed [crds_pkg::SPAN_W-1:0]    span,
	input  wire                                  rd_en,
	input  wire [$clog2(MAX_CIRCLES)-1:0]        rd_addr,
	output logic signed [crds_pkg::OFF_W-1:0]    rd_data,
	output logic                                 busy
);
	localparam int AW = $clog2(MAX_CIRCLES);
	localparam int SW = crds_pkg::SPAN_W;
	localparam int CW = $clog2(SW + 1);
	localparam logic [AW-1:0] LAST = AW'(MAX_CIRCLES - 1);
	localparam logic [CW-1:0] CNT_LAST = CW'(SW - 1);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_LOAD = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_FILL = 4'b1000
	} tbl_state_t;

	tbl_state_t state_q;
	logic [SW-1:0] dvd_q;
	logic [AW-1:0] rem_q;
	logic [CW-1:0] cnt_q;
	logic neg_q;
	logic [AW-1:0] p_q;
	logic [SW-1:0] acc_q;
	logic [AW-1:0] racc_q;
	logic signed [crds_pkg::OFF_W-1:0] mem [MAX_CIRCLES];

	logic [SW-1:0] mag;
	logic [AW:0] rem_sh;
	logic ge;
	logic kz;
	logic [SW-1:0] step;
	logic [AW-1:0] rstep;
	logic [AW:0] rsum;
	logic carry;
	logic signed [crds_pkg::OFF_W-1:0] entry;

	assign mag = span[SW-1] ? SW'(-span) : SW'(span);
	assign rem_sh = {rem_q, dvd_q[SW-1]};
	assign ge = rem_sh >= {1'b0, divisor};
	assign kz = divisor == '0;
	assign step = kz ? '0 : dvd_q;
	assign rstep = kz ? '0 : rem_q;
	assign rsum = {1'b0, racc_q} + {1'b0, rstep};
	assign carry = !kz && (rsum >= {1'b0, divisor});
	assign entry = neg_q ? -$signed({1'b0, acc_q}) : $signed({1'b0, acc_q});
	assign busy = state_q != ST_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			cnt_q <= '0;
			p_q <= '0;
		end else if (restart) begin
			state_q <= ST_LOAD;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					state_q <= ST_DIV;
					cnt_q <= '0;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_LAST) begin
						state_q <= ST_FILL;
						p_q <= '0;
					end
				end
				ST_FILL: begin
					p_q <= p_q + 1'b1;
					if (p_q == LAST)
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD) begin
			dvd_q <= mag;
			rem_q <= '0;
			neg_q <= span[SW-1];
		end else if (state_q == ST_DIV) begin
			dvd_q <= {dvd_q[SW-2:0], ge};
			rem_q <= ge ? AW'(rem_sh - {1'b0, divisor}) : AW'(rem_sh);
		end
		if (state_q == ST_DIV) begin
			acc_q <= '0;
			racc_q <= '0;
		end else if (state_q == ST_FILL) begin
			acc_q <= acc_q + step + SW'(carry);
			racc_q <= carry ? AW'(rsum - {1'b0, divisor}) : AW'(rsum);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FILL)
			mem[p_q] <= entry;
	end

	always_ff @(posedge clk) begin
		if (rd_en)
			rd_data <= mem[rd_addr];
	end

	`CRDS_ASSERT_NEXT(a_fill_ends, state_q == ST_FILL && p_q == LAST && !restart, state_q == ST_IDLE, "fill sweep did not end")
	`CRDS_ASSERT_NEXT(a_restart_reload, restart, state_q == ST_LOAD, "write did not restart table build")
endmodule
`default_nettype wire

// File: src/crds_sincos.sv
// pipelined sine and cosine of a 32-bit turn phase, octant folding plus polynomials
// seven register stages; uses crds_pkg
`timescale 1ns / 1ps
`default_nettype none
`include "cone_ray_direction_sampler_core_assert.svh"
module crds_sincos (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              in_vld,
	input  wire [crds_pkg::PHASE_W-1:0]      phase,
	output logic                             out_vld,
	output crds_pkg::sc_t                    sc
);
	localparam int QW = crds_pkg::Q30_W;

	function automatic logic [QW-1:0] umul30(input logic [QW-1:0] a, input logic [QW-1:0] b);
		logic [2*QW-1:0] p;
		p = {{QW{1'b0}}, a} * {{QW{1'b0}}, b} + 62'd536870912;
		return p[60:30];
	endfunction

	logic [6:0] vld_q;
	logic [2:0] k_s1, k_s2, k_s3, k_s4, k_s5, k_s6;
	logic [QW-1:0] x_s1, x_s2, x_s3, x_s4, x_s5;
	logic [QW-1:0] x2_s2, x2_s3, x2_s4, x2_s5;
	logic [QW-1:0] t_s3, t_s4, t_s5, u_s3, u_s4, u_s5;
	logic [QW-1:0] s0_s6, c0_s6;
	crds_pkg::sc_t sc_s7;

	logic [29:0] rf;
	logic [61:0] xprod;
	logic [2:0] kp1, kp2;
	logic signed [crds_pkg::SC_W-1:0] sv, cv;

	assign rf = phase[29] ? (30'd536870912 - {1'b0, phase[28:0]}) : {1'b0, phase[28:0]};
	assign xprod = {32'b0, rf} * {30'b0, crds_pkg::PI_Q30};
	assign kp1 = k_s6 + 3'd1;
	assign kp2 = k_s6 + 3'd2;
	assign sv = $signed({1'b0, kp1[1] ? c0_s6 : s0_s6});
	assign cv = $signed({1'b0, kp1[1] ? s0_s6 : c0_s6});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else
			vld_q <= {vld_q[5:0], in_vld};
	end

	always_ff @(posedge clk) begin
		k_s1 <= phase[31:29];
		x_s1 <= {1'b0, xprod[60:31]};
		k_s2 <= k_s1;
		x_s2 <= x_s1;
		x2_s2 <= umul30(x_s1, x_s1);
		k_s3 <= k_s2;
		x_s3 <= x_s2;
		x2_s3 <= x2_s2;
		t_s3 <= crds_pkg::C_INV120 - umul30(x2_s2, crds_pkg::C_INV5040);
		u_s3 <= crds_pkg::C_INV720 - umul30(x2_s2, crds_pkg::C_INV40320);
		k_s4 <= k_s3;
		x_s4 <= x_s3;
		x2_s4 <= x2_s3;
		t_s4 <= crds_pkg::C_INV6 - umul30(x2_s3, t_s3);
		u_s4 <= crds_pkg::C_INV24 - umul30(x2_s3, u_s3);
		k_s5 <= k_s4;
		x_s5 <= x_s4;
		x2_s5 <= x2_s4;
		t_s5 <= crds_pkg::Q30_ONE - umul30(x2_s4, t_s4);
		u_s5 <= crds_pkg::Q30_HALF - umul30(x2_s4, u_s4);
		k_s6 <= k_s5;
		s0_s6 <= umul30(x_s5, t_s5);
		c0_s6 <= crds_pkg::Q30_ONE - umul30(x2_s5, u_s5);
		sc_s7.s <= k_s6[2] ? -sv : sv;
		sc_s7.c <= kp2[2] ? -cv : cv;
	end

	assign out_vld = vld_q[6];
	assign sc = sc_s7;

	`CRDS_ASSERT_CLK(a_unit_range, !vld_q[6] || (sc_s7.s <= 32'sd1073741824 && sc_s7.s >= -32'sd1073741824 && sc_s7.c <= 32'sd1073741824 && sc_s7.c >= -32'sd1073741824), "sine or cosine out of unit range")
endmodule
`default_nettype wire

// File: src/crds_combine.sv
// tilt rotation: products of the four sine/cosine pairs into three direction cosines
// five register stages; uses crds_pkg
`timescale 1ns / 1ps
`default_nettype none
module crds_combine (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                in_vld,
	input  wire                                in_clamp,
	input  wire crds_pkg::sc_t                 az,
	input  wire crds_pkg::sc_t                 th,
	input  wire crds_pkg::sc_t                 tx,
	input  wire crds_pkg::sc_t                 ty,
	output logic                               out_vld,
	output logic                               out_clamp,
	output logic signed [crds_pkg::DIR_W-1:0]  dir_x,
	output logic signed [crds_pkg::DIR_W-1:0]  dir_y,
	output logic signed [crds_pkg::DIR_W-1:0]  dir_z
);
	typedef crds_pkg::acc_t acc_t;

	function automatic acc_t smul30(input acc_t a, input acc_t b);
		logic signed [2*crds_pkg::ACC_W-1:0] p;
		p = a * b + 68'sd536870912;
		return p[63:30];
	endfunction

	function automatic logic signed [crds_pkg::DIR_W-1:0] sat32(input acc_t v);
		if (v > 34'sd2147483647)
			return 32'sh7fffffff;
		else if (v < -34'sd2147483648)
			return 32'sh80000000;
		else
			return v[31:0];
	endfunction

	logic [4:0] vld_q, clamp_q;
	acc_t ca, sa, ct, st, cx, sx, cy, sy;
	acc_t p1_s1, p2_s1, p3_s1, p4_s1, p5_s1, p6_s1, p7_s1, p8_s1;
	acc_t st_s1, ct_s1, sx_s1, sy_s1;
	acc_t q1_s2, q3_s2, q5_s2, q6_s2, q7_s2, q8_s2, p1_s2, p4_s2, st_s2;
	acc_t a1_s3, r9_s3, am_s3, an_s3, q3_s3, st_s3;
	acc_t r1_s4, q3_s4, am_s4, an_s4;
	logic signed [crds_pkg::DIR_W-1:0] x_s5, y_s5, z_s5;

	assign ca = acc_t'(az.c);
	assign sa = acc_t'(az.s);
	assign ct = acc_t'(th.c);
	assign st = acc_t'(th.s);
	assign cx = acc_t'(tx.c);
	assign sx = acc_t'(tx.s);
	assign cy = acc_t'(ty.c);
	assign sy = acc_t'(ty.s);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			clamp_q <= '0;
		end else begin
			vld_q <= {vld_q[3:0], in_vld};
			clamp_q <= {clamp_q[3:0], in_clamp};
		end
	end

	always_ff @(posedge clk) begin
		p1_s1 <= smul30(ca, cy);
		p2_s1 <= smul30(sa, sy);
		p3_s1 <= smul30(cx, ct);
		p4_s1 <= smul30(ct, sx);
		p5_s1 <= smul30(cx, sa);
		p6_s1 <= smul30(ca, sy);
		p7_s1 <= smul30(cy, cx);
		p8_s1 <= smul30(cy, sa);
		st_s1 <= st;
		ct_s1 <= ct;
		sx_s1 <= sx;
		sy_s1 <= sy;

		q1_s2 <= smul30(p2_s1, sx_s1);
		q3_s2 <= smul30(p3_s1, sy_s1);
		q5_s2 <= smul30(p5_s1, st_s1);
		q6_s2 <= smul30(-p6_s1, st_s1);
		q7_s2 <= smul30(p7_s1, ct_s1);
		q8_s2 <= smul30(p8_s1, sx_s1);
		p1_s2 <= p1_s1;
		p4_s2 <= p4_s1;
		st_s2 <= st_s1;

		a1_s3 <= p1_s2 + q1_s2;
		r9_s3 <= smul30(q8_s2, st_s2);
		am_s3 <= q5_s2 - p4_s2;
		an_s3 <= q6_s2 + q7_s2;
		q3_s3 <= q3_s2;
		st_s3 <= st_s2;

		r1_s4 <= smul30(a1_s3, st_s3);
		q3_s4 <= q3_s3;
		am_s4 <= am_s3;
		an_s4 <= an_s3 + r9_s3;

		x_s5 <= sat32(r1_s4 + q3_s4);
		y_s5 <= sat32(am_s4);
		z_s5 <= sat32(an_s4);
	end

	assign out_vld = vld_q[4];
	assign out_clamp = clamp_q[4];
	assign dir_x = x_s5;
	assign dir_y = y_s5;
	assign dir_z = z_s5;
endmodule
`default_nettype wire

// File: src/cone_ray_direction_sampler_core.sv
// cone ray direction sampler: registers, opening angle, phase conversion, top level
// uses crds_pkg, crds_offset_table, crds_sincos, crds_combine
//
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------------------
//  item in  | start, busy          | azimuth_fraction, circle_pick, spread_fraction
//  result   | done (one cycle)     | dir_x, dir_y, dir_z, pick_clamped
//  config   | cfg_valid, cfg_ready | cfg_index, cfg_data
//
// one item per cycle while busy is low; each item passes, after its start beat,
// through 4 angle/phase stages, 7 sine/cosine stages and 5 rotation stages
// after reset and after every config write the offset table is rebuilt:
// a load, the divider steps over all span bits, then a fill of all MAX_CIRCLES entries, busy high
// the pipeline never stalls; the receiver takes each result in its done cycle
`timescale 1ns / 1ps
`default_nettype none
`include "cone_ray_direction_sampler_core_assert.svh"
module cone_ray_direction_sampler_core #(
	parameter int MAX_CIRCLES  = 64,
	parameter int UNIFORM_BITS = 24
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   start,
	output logic                                  busy,
	input  wire [UNIFORM_BITS-1:0]                azimuth_fraction,
	input  wire [crds_pkg::PICK_W-1:0]            circle_pick,
	input  wire [UNIFORM_BITS-1:0]                spread_fraction,
	output logic                                  done,
	output logic signed [crds_pkg::DIR_W-1:0]     dir_x,
	output logic signed [crds_pkg::DIR_W-1:0]     dir_y,
	output logic signed [crds_pkg::DIR_W-1:0]     dir_z,
	output logic                                  pick_clamped,
	input  wire                                   cfg_valid,
	output logic                                  cfg_ready,
	input  wire [crds_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire [crds_pkg::ANGLE_W-1:0]           cfg_data
);
	localparam int AW = $clog2(MAX_CIRCLES);
	localparam int NW = ($clog2(MAX_CIRCLES + 1) > crds_pkg::NCFG_W) ?
		$clog2(MAX_CIRCLES + 1) : crds_pkg::NCFG_W;
	localparam int UB = UNIFORM_BITS;
	localparam int JW = UB + 1 + crds_pkg::ANGLE_W;
	localparam int TW = crds_pkg::THETA_W;
	localparam int PW = crds_pkg::PHASE_W;
	localparam int LAT = 16;

	logic [crds_pkg::NCFG_W-1:0] num_circles_q;
	logic signed [crds_pkg::ANGLE_W-1:0] min_opening_q, max_opening_q, opening_spread_q;
	logic signed [crds_pkg::ANGLE_W-1:0] tilt_about_x_q, tilt_about_y_q;

	logic accept;
	logic [NW-1:0] nc_x, n_eff, pick_x, pick_eff;
	logic clamp;
	logic signed [UB:0] centered;
	logic signed [JW-1:0] jprod;
	logic signed [crds_pkg::OFF_W-1:0] offset;
	logic signed [crds_pkg::SPAN_W-1:0] span;

	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic clamp_s1, clamp_s2, clamp_s3, clamp_s4;
	logic [PW-1:0] azph_s1, azph_s2, azph_s3, azph_s4;
	logic signed [JW-1:0] jprod_s1;
	logic signed [TW-1:0] theta_s2;
	logic signed [47:0] mh_s3;
	logic [47:0] ml_s3;
	logic [PW-1:0] phx_s3, phy_s3, phx_s4, phy_s4, phth_s4;
	logic [6:0] clamp_sc_q;

	logic signed [JW-1:0] jbias;
	logic signed [crds_pkg::SPAN_W-1:0] jit;
	logic signed [61:0] tx_prod, ty_prod;
	logic signed [30:0] c_turn;
	logic [59:0] thsum;

	logic v_az, v_th, v_tx, v_ty;
	crds_pkg::sc_t sc_az, sc_th, sc_tx, sc_ty;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_circles_q <= 7'd1;
			min_opening_q <= '0;
			max_opening_q <= '0;
			opening_spread_q <= '0;
			tilt_about_x_q <= '0;
			tilt_about_y_q <= '0;
		end else if (cfg_valid) begin
			unique case (crds_pkg::cfg_idx_t'(cfg_index))
				crds_pkg::CFG_NUM_CIRCLES: num_circles_q <= cfg_data[crds_pkg::NCFG_W-1:0];
				crds_pkg::CFG_MIN_OPENING: min_opening_q <= cfg_data;
				crds_pkg::CFG_MAX_OPENING: max_opening_q <= cfg_data;
				crds_pkg::CFG_OPENING_SPREAD: opening_spread_q <= cfg_data;
				crds_pkg::CFG_TILT_ABOUT_X: tilt_about_x_q <= cfg_data;
				crds_pkg::CFG_TILT_ABOUT_Y: tilt_about_y_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign accept = start && !busy;
	assign nc_x = NW'(num_circles_q);
	assign n_eff = (num_circles_q == '0) ? NW'(1) :
		(nc_x > NW'(MAX_CIRCLES)) ? NW'(MAX_CIRCLES) : nc_x;
	assign pick_x = NW'(circle_pick);
	assign clamp = pick_x >= n_eff;
	assign pick_eff = clamp ? n_eff - 1'b1 : pick_x;
	assign span = crds_pkg::SPAN_W'(max_opening_q) - crds_pkg::SPAN_W'(min_opening_q);

	crds_offset_table #(
		.MAX_CIRCLES(MAX_CIRCLES)
	) u_table (
		.clk(clk),
		.arst_n(arst_n),
		.restart(cfg_valid),
		.divisor(AW'(n_eff - 1'b1)),
		.span(span),
		.rd_en(accept),
		.rd_addr(AW'(pick_eff)),
		.rd_data(offset),
		.busy(busy)
	);

	assign centered = $signed({1'b0, spread_fraction}) - $signed({2'b01, {(UB-1){1'b0}}});
	assign jprod = centered * opening_spread_q;
	assign jbias = jprod_s1[JW-1] ? $signed({{(JW-UB){1'b0}}, {UB{1'b1}}}) : '0;
	assign jit = crds_pkg::SPAN_W'((jprod_s1 + jbias) >>> UB);
	assign c_turn = $signed({1'b0, crds_pkg::TURNS_PER_RAD});
	assign tx_prod = tilt_about_x_q * c_turn;
	assign ty_prod = tilt_about_y_q * c_turn;
	assign thsum = {mh_s3[41:0], 18'b0} + {12'b0, ml_s3};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			clamp_sc_q <= '0;
		end else begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			clamp_sc_q <= {clamp_sc_q[5:0], clamp_s4};
		end
	end

	always_ff @(posedge clk) begin
		clamp_s1 <= clamp;
		azph_s1 <= PW'(azimuth_fraction) << (PW - UB);
		jprod_s1 <= jprod;

		clamp_s2 <= clamp_s1;
		azph_s2 <= azph_s1;
		theta_s2 <= TW'(min_opening_q) + TW'(offset) + TW'(jit);

		clamp_s3 <= clamp_s2;
		azph_s3 <= azph_s2;
		mh_s3 <= $signed(theta_s2[TW-1:18]) * c_turn;
		ml_s3 <= {30'b0, theta_s2[17:0]} * {18'b0, crds_pkg::TURNS_PER_RAD};
		phx_s3 <= tx_prod[59:28];
		phy_s3 <= ty_prod[59:28];

		clamp_s4 <= clamp_s3;
		azph_s4 <= azph_s3;
		phth_s4 <= thsum[59:28];
		phx_s4 <= phx_s3;
		phy_s4 <= phy_s3;
	end

	crds_sincos u_sc_az (.clk(clk), .arst_n(arst_n), .in_vld(vld_s4), .phase(azph_s4),
		.out_vld(v_az), .sc(sc_az));
	crds_sincos u_sc_th (.clk(clk), .arst_n(arst_n), .in_vld(vld_s4), .phase(phth_s4),
		.out_vld(v_th), .sc(sc_th));
	crds_sincos u_sc_tx (.clk(clk), .arst_n(arst_n), .in_vld(vld_s4), .phase(phx_s4),
		.out_vld(v_tx), .sc(sc_tx));
	crds_sincos u_sc_ty (.clk(clk), .arst_n(arst_n), .in_vld(vld_s4), .phase(phy_s4),
		.out_vld(v_ty), .sc(sc_ty));

	crds_combine u_combine (
		.clk(clk),
		.arst_n(arst_n),
		.in_vld(v_az && v_th && v_tx && v_ty),
		.in_clamp(clamp_sc_q[6]),
		.az(sc_az),
		.th(sc_th),
		.tx(sc_tx),
		.ty(sc_ty),
		.out_vld(done),
		.out_clamp(pick_clamped),
		.dir_x(dir_x),
		.dir_y(dir_y),
		.dir_z(dir_z)
	);

	`CRDS_ASSERT_CLK(a_done_latency, done == $past(start && !busy, LAT), "result beat lost or invented")
	`CRDS_ASSERT_CLK(a_lanes_aligned, v_az == v_th && v_tx == v_ty && v_az == v_tx, "sine lanes out of step")
endmodule
`default_nettype wire

// File: tb/cone_ray_direction_checker.sv
// checker for the cone ray direction sampler: watches item, config and result beats,
// predicts each unit direction from its own copy of the registers and compares
// depends on crds_pkg
`timescale 1ns / 1ps
module cone_ray_direction_checker (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                start,
	input  wire                busy,
	input  wire [23:0]         azimuth_fraction,
	input  wire [5:0]          circle_pick,
	input  wire [23:0]         spread_fraction,
	input  wire                done,
	input  wire signed [31:0]  dir_x,
	input  wire signed [31:0]  dir_y,
	input  wire signed [31:0]  dir_z,
	input  wire                pick_clamped,
	input  wire                cfg_valid,
	input  wire                cfg_ready,
	input  wire [2:0]          cfg_index,
	input  wire [31:0]         cfg_data,
	output int                 errors,
	output int                 outstanding
);
	typedef struct {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic        clamped;
	} direction_t;

	direction_t pending_dirs[$];

	logic [6:0] cones;
	longint     open_min, open_max, spread_width, tilt_x, tilt_y;

	assign outstanding = pending_dirs.size();

	function automatic logic [63:0] umul_q30(input logic [63:0] a, input logic [63:0] b);
		return (a * b + (64'd1 << 29)) >> 30;
	endfunction

	function automatic longint smul_q30(input longint a, input longint b);
		logic [63:0] p;
		p = 64'(a * b) + (64'd1 << 29) + (64'd1 << 62);
		return longint'({30'd0, p[63:30]}) - (64'sd1 <<< 32);
	endfunction

	function automatic logic [31:0] angle_to_phase(input longint a);
		logic [63:0] m;
		m = 64'(a) * 64'd683565276;
		return m[59:28];
	endfunction

	function automatic void phase_sin_cos(input logic [31:0] ph, output longint s,
			output longint c);
		logic [2:0]  k, k1, k2;
		logic [63:0] r, x, x2, t, s0, c0;
		k = ph[31:29];
		r = {35'd0, ph[28:0]};
		if (k[0])
			r = (64'd1 << 29) - r;
		x  = (r * 64'(crds_pkg::PI_Q30)) >> 31;
		x2 = umul_q30(x, x);
		t  = 64'(crds_pkg::C_INV120) - umul_q30(x2, 64'(crds_pkg::C_INV5040));
		t  = 64'(crds_pkg::C_INV6) - umul_q30(x2, t);
		t  = 64'(crds_pkg::Q30_ONE) - umul_q30(x2, t);
		s0 = umul_q30(x, t);
		t  = 64'(crds_pkg::C_INV720) - umul_q30(x2, 64'(crds_pkg::C_INV40320));
		t  = 64'(crds_pkg::C_INV24) - umul_q30(x2, t);
		t  = 64'(crds_pkg::Q30_HALF) - umul_q30(x2, t);
		c0 = 64'(crds_pkg::Q30_ONE) - umul_q30(x2, t);
		k1 = k + 3'd1;
		k2 = k + 3'd2;
		if (k1[1]) begin
			s = longint'(c0);
			c = longint'(s0);
		end else begin
			s = longint'(s0);
			c = longint'(c0);
		end
		if (k[2])
			s = -s;
		if (k2[2])
			c = -c;
	endfunction

	function automatic logic [31:0] clip32(input longint v);
		if (v > 64'sd2147483647)
			v = 64'sd2147483647;
		if (v < -64'sd2147483648)
			v = -64'sd2147483648;
		return v[31:0];
	endfunction

	function automatic direction_t predict_direction(input logic [23:0] az,
			input logic [5:0] pick_in, input logic [23:0] sf);
		direction_t d;
		longint n, pick, theta, centered;
		longint sa, ca, st, ct, sx, cx, sy, cy, al, am, an;
		n = longint'(cones);
		pick = longint'(pick_in);
		d.clamped = 1'b0;
		if (n < 1)
			n = 1;
		if (n > 64)
			n = 64;
		if (pick >= n) begin
			pick = n - 1;
			d.clamped = 1'b1;
		end
		theta = open_min;
		if (n > 1)
			theta += ((open_max - open_min) * pick) / (n - 1);
		centered = longint'(sf) - 64'sd8388608;
		theta += (centered * spread_width) / 64'sd16777216;
		phase_sin_cos({az, 8'd0}, sa, ca);
		phase_sin_cos(angle_to_phase(theta), st, ct);
		phase_sin_cos(angle_to_phase(tilt_x), sx, cx);
		phase_sin_cos(angle_to_phase(tilt_y), sy, cy);
		al = smul_q30(smul_q30(ca, cy) + smul_q30(smul_q30(sa, sy), sx), st)
			+ smul_q30(smul_q30(cx, ct), sy);
		am = -smul_q30(ct, sx) + smul_q30(smul_q30(cx, sa), st);
		an = smul_q30(-smul_q30(ca, sy), st)
			+ smul_q30(smul_q30(cy, cx), ct)
			+ smul_q30(smul_q30(smul_q30(cy, sa), sx), st);
		d.x = clip32(al);
		d.y = clip32(am);
		d.z = clip32(an);
		return d;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		direction_t want;
		if (!arst_n) begin
			cones <= 7'd1;
			open_min <= 0;
			open_max <= 0;
			spread_width <= 0;
			tilt_x <= 0;
			tilt_y <= 0;
			errors <= 0;
			pending_dirs.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (crds_pkg::cfg_idx_t'(cfg_index))
					crds_pkg::CFG_NUM_CIRCLES:    cones <= cfg_data[6:0];
					crds_pkg::CFG_MIN_OPENING:    open_min <= longint'($signed(cfg_data));
					crds_pkg::CFG_MAX_OPENING:    open_max <= longint'($signed(cfg_data));
					crds_pkg::CFG_OPENING_SPREAD: spread_width <= longint'($signed(cfg_data));
					crds_pkg::CFG_TILT_ABOUT_X:   tilt_x <= longint'($signed(cfg_data));
					crds_pkg::CFG_TILT_ABOUT_Y:   tilt_y <= longint'($signed(cfg_data));
					default: ;
				endcase
			end
			if (done) begin
				if (pending_dirs.size() == 0) begin
					$display("%0t unexpected result beat: x=%h y=%h z=%h clamped=%b",
						$time, dir_x, dir_y, dir_z, pick_clamped);
					errors <= errors + 1;
				end else begin
					want = pending_dirs.pop_front();
					if (want.x !== dir_x || want.y !== dir_y || want.z !== dir_z
							|| want.clamped !== pick_clamped) begin
						$display("%0t mismatch: expected x=%h y=%h z=%h clamped=%b",
							$time, want.x, want.y, want.z, want.clamped);
						$display("%0t            actual x=%h y=%h z=%h clamped=%b",
							$time, dir_x, dir_y, dir_z, pick_clamped);
						errors <= errors + 1;
					end
				end
			end
			if (start && !busy)
				pending_dirs = {pending_dirs, predict_direction(azimuth_fraction,
					circle_pick, spread_fraction)};
		end
	end
endmodule

// File: tb/testbench.sv
// top of the cone ray direction sampler testbench: clock, reset, item and config stimulus
// depends on crds_pkg, cone_ray_direction_sampler_core and cone_ray_direction_checker
`timescale 1ns / 1ps
module testbench;
	localparam logic [2:0] CFG_SPARE_LO = 3'd6;
	localparam logic [2:0] CFG_SPARE_HI = 3'd7;
	localparam int CYCLE_LIMIT = 400000;
	localparam longint PI_ANGLE = 843314857;

	logic clk, arst_n, start, cfg_valid;
	logic [23:0] azimuth_fraction, spread_fraction;
	logic [5:0] circle_pick;
	logic [2:0] cfg_index;
	logic [31:0] cfg_data;
	wire busy, done, pick_clamped, cfg_ready;
	wire signed [31:0] dir_x, dir_y, dir_z;
	int errors, outstanding, cycles, items_sent, cfg_writes;
	logic [6:0] cone_setting;

	cone_ray_direction_sampler_core DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.azimuth_fraction(azimuth_fraction), .circle_pick(circle_pick),
		.spread_fraction(spread_fraction), .done(done), .dir_x(dir_x), .dir_y(dir_y),
		.dir_z(dir_z), .pick_clamped(pick_clamped), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	cone_ray_direction_checker checker_i (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.azimuth_fraction(azimuth_fraction), .circle_pick(circle_pick),
		.spread_fraction(spread_fraction), .done(done), .dir_x(dir_x), .dir_y(dir_y),
		.dir_z(dir_z), .pick_clamped(pick_clamped), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.errors(errors), .outstanding(outstanding)
	);

	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAIL");
			$finish;
		end
	end

	task automatic send_item(input logic [23:0] az, input logic [5:0] pick,
			input logic [23:0] sf, input bit may_idle);
		while (may_idle && $urandom_range(99) < 28) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		azimuth_fraction <= az;
		circle_pick <= pick;
		spread_fraction <= sf;
		do @(posedge clk); while (busy);
		items_sent++;
	endtask

	// write beat; valid stays up until the next write idles or the caller ends the burst
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
		while ($urandom_range(99) < 28) begin
			cfg_valid <= 1'b0;
			@(posedge clk);
		end
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_writes++;
		if (idx == crds_pkg::CFG_NUM_CIRCLES)
			cone_setting = value[6:0];
	endtask

	task automatic drain;
		start <= 1'b0;
		cfg_valid <= 1'b0;
		while (outstanding != 0)
			@(posedge clk);
	endtask

	task automatic program_all(input logic [31:0] n, input logic [31:0] lo,
			input logic [31:0] hi, input logic [31:0] spr, input logic [31:0] tx,
			input logic [31:0] ty);
		write_reg(crds_pkg::CFG_NUM_CIRCLES, n);
		write_reg(crds_pkg::CFG_MIN_OPENING, lo);
		write_reg(crds_pkg::CFG_MAX_OPENING, hi);
		write_reg(crds_pkg::CFG_OPENING_SPREAD, spr);
		write_reg(crds_pkg::CFG_TILT_ABOUT_X, tx);
		write_reg(crds_pkg::CFG_TILT_ABOUT_Y, ty);
		cfg_valid <= 1'b0;
	endtask

	task automatic directed_items;
		send_item(24'h000000, 6'd0, 24'h000000, 1'b0);
		send_item(24'hFFFFFF, 6'd63, 24'hFFFFFF, 1'b0);
		send_item(24'h800000, 6'd1, 24'h800000, 1'b0);
		send_item(24'h400000, 6'd0, 24'h7FFFFF, 1'b0);
		send_item(24'hC00000, 6'd63, 24'h000001, 1'b1);
		send_item(24'h200000, 6'd32, 24'h555555, 1'b1);
		send_item(24'h600000, 6'd2, 24'hAAAAAA, 1'b1);
		send_item(24'hA5A5A5, 6'd21, 24'h5A5A5A, 1'b0);
	endtask

	function automatic logic [31:0] rand_angle;
		int r;
		r = $urandom_range(99);
		if (r < 8)
			return 32'h80000000;
		if (r < 16)
			return 32'h7FFFFFFF;
		if (r < 30)
			return $urandom;
		return 32'(longint'($urandom_range(2 * PI_ANGLE)) - PI_ANGLE);
	endfunction

	function automatic logic [31:0] rand_cones;
		case ($urandom_range(7))
			0: return 32'd0;
			1: return 32'd1;
			2: return 32'd64;
			3: return {24'($urandom_range(32'hFFFFFF)), 1'b1, 7'($urandom_range(127, 65))};
			default: return 32'($urandom_range(64, 2));
		endcase
	endfunction

	initial begin
		int n_eff;
		bit quiet;
		arst_n = 1'b0;
		start = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		azimuth_fraction = '0;
		circle_pick = '0;
		spread_fraction = '0;
		cycles = 0;
		items_sent = 0;
		cfg_writes = 0;
		cone_setting = 7'd1;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings, then the extremes, then single and zero cone counts
		directed_items();
		drain();
		program_all(32'd64, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000,
			32'h7FFFFFFF);
		directed_items();
		drain();
		write_reg(CFG_SPARE_LO, 32'hFFFFFFFF);
		write_reg(CFG_SPARE_HI, 32'h12345678);
		program_all(32'd1, 32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF,
			32'h80000000);
		directed_items();
		drain();
		program_all(32'hFFFFFF80, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
		send_item(24'h123456, 6'd0, 24'hFEDCBA, 1'b0);
		send_item(24'h654321, 6'd63, 24'h000000, 1'b0);
		drain();

		for (int ph = 0; ph < 12; ph++) begin
			if ($urandom_range(3) == 0)
				write_reg($urandom_range(1) ? CFG_SPARE_LO : CFG_SPARE_HI, $urandom);
			program_all(rand_cones(), rand_angle(), rand_angle(), rand_angle(),
				rand_angle(), rand_angle());
			n_eff = (cone_setting == 0) ? 1 : (cone_setting > 64) ? 64 : cone_setting;
			for (int i = 0; i < 56; i++) begin
				quiet = (ph == 4 || ph == 5);
				send_item(24'($urandom), ($urandom_range(99) < 75)
					? 6'($urandom_range(n_eff - 1)) : 6'($urandom), 24'($urandom), !quiet);
			end
			drain();
		end

		repeat (40) @(posedge clk);
		$display("sent %0d direction samples over %0d register writes", items_sent, cfg_writes);
		$display("cone counts 0, 1, 64 and above range, extreme angles and clamped picks");
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
